@@ design/adcv_pkg.sv @@
// shared types, constants and helper functions for the lcd voltmeter block
package adcv_pkg;

    // digit count and packed digit word, index 0 is the most significant digit
    localparam int DIGIT_COUNT = 5;
    typedef logic [DIGIT_COUNT-1:0][3:0] digits_t;

    // scale register limits and reset value
    localparam logic [8:0] SCALE_RESET = 9'd196;
    localparam logic [8:0] SCALE_MIN   = 9'd1;
    localparam logic [8:0] SCALE_MAX   = 9'd392;

    // lcd codes
    localparam logic [7:0] LCD_CLEAR  = 8'h01;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_UNIT  = 8'h76;

    // beat positions inside one redraw run
    localparam logic [2:0] BEAT_CLEAR  = 3'd0;
    localparam logic [2:0] BEAT_DIG0   = 3'd1;
    localparam logic [2:0] BEAT_POINT  = 3'd2;
    localparam logic [2:0] BEAT_DIG1   = 3'd3;
    localparam logic [2:0] BEAT_DIG2   = 3'd4;
    localparam logic [2:0] BEAT_DIG3   = 3'd5;
    localparam logic [2:0] BEAT_DIG4   = 3'd6;
    localparam logic [2:0] BEAT_UNIT   = 3'd7;

    // reciprocal of ten, exact quotient for any 17-bit value with a 20-bit shift
    localparam logic [33:0] RECIP_TEN = 34'd104858;

    // front to queue push beat
    typedef struct packed {
        logic    valid;
        digits_t digits;
    } push_t;

    // queue status seen by both sides
    typedef struct packed {
        logic    full;
        logic    empty;
        digits_t head;
    } queue_stat_t;

    // quotient and remainder of a division by ten
    typedef struct packed {
        logic [13:0] quot;
        logic [3:0]  rem;
    } div10_t;

    function automatic div10_t div10(input logic [16:0] x);
        logic [33:0] prod;
        logic [16:0] back;
        div10_t      res;
        prod     = {17'd0, x} * RECIP_TEN;
        res.quot = prod[33:20];
        back     = {res.quot, 3'd0} + {2'd0, res.quot, 1'd0};
        res.rem  = 4'(x - back);
        return res;
    endfunction

    // byte and register select for one beat of a redraw run
    function automatic logic [8:0] beat_word(input logic [2:0] idx, input digits_t d);
        logic [8:0] w;
        unique case (idx)
            BEAT_CLEAR: w = {1'b0, LCD_CLEAR};
            BEAT_DIG0:  w = {1'b1, ASCII_ZERO + {4'd0, d[0]}};
            BEAT_POINT: w = {1'b1, CHAR_POINT};
            BEAT_DIG1:  w = {1'b1, ASCII_ZERO + {4'd0, d[1]}};
            BEAT_DIG2:  w = {1'b1, ASCII_ZERO + {4'd0, d[2]}};
            BEAT_DIG3:  w = {1'b1, ASCII_ZERO + {4'd0, d[3]}};
            BEAT_DIG4:  w = {1'b1, ASCII_ZERO + {4'd0, d[4]}};
            BEAT_UNIT:  w = {1'b1, CHAR_UNIT};
            default:    w = {1'b0, LCD_CLEAR};
        endcase
        return w;
    endfunction

endpackage

@@ design/adcv_front.sv @@
// front pipeline: scale multiply, digit extraction and change detection
module adcv_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           sample,
    input  logic [8:0]           scale,
    input  adcv_pkg::queue_stat_t qstat,
    output adcv_pkg::push_t      push
);

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage payloads
    logic [16:0]      prod1_reg;
    logic [13:0]      q2_reg;
    logic [9:0]       q3_reg;
    logic [6:0]       q4_reg;
    logic [3:0]       d2_reg, d3_reg, d4_reg;
    logic [3:0]       d3_s4_reg, d4_s3_reg, d4_s4_reg;
    adcv_pkg::digits_t dig5_reg;
    adcv_pkg::digits_t shown_reg;

    logic [8:0]       scale_clamped;
    logic [16:0]      prod_next;
    adcv_pkg::div10_t dv2, dv3, dv4, dv5;
    logic             changed;
    logic             advance;

    // clamp scale into its legal range
    always_comb
    begin
        if (scale < adcv_pkg::SCALE_MIN)
            scale_clamped = adcv_pkg::SCALE_MIN;
        else if (scale > adcv_pkg::SCALE_MAX)
            scale_clamped = adcv_pkg::SCALE_MAX;
        else
            scale_clamped = scale;
    end

    assign prod_next = {9'd0, sample} * {8'd0, scale_clamped};

    // one digit per stage, least significant first
    assign dv2 = adcv_pkg::div10(prod1_reg);
    assign dv3 = adcv_pkg::div10({3'd0, q2_reg});
    assign dv4 = adcv_pkg::div10({7'd0, q3_reg});
    assign dv5 = adcv_pkg::div10({10'd0, q4_reg});

    // compare against the digits on the display
    assign changed = (dig5_reg != shown_reg);
    assign advance = !(v5_reg && changed && qstat.full);
    assign in_ready = advance;

    assign push.valid  = v5_reg && changed && !qstat.full;
    assign push.digits = dig5_reg;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage payloads, early digits delayed to stay with their sample
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod1_reg   <= prod_next;
            q2_reg      <= dv2.quot;
            d4_reg      <= dv2.rem;
            q3_reg      <= 10'(dv3.quot);
            d3_reg      <= dv3.rem;
            d4_s3_reg   <= d4_reg;
            q4_reg      <= 7'(dv4.quot);
            d2_reg      <= dv4.rem;
            d3_s4_reg   <= d3_reg;
            d4_s4_reg   <= d4_s3_reg;
            dig5_reg[0] <= 4'(dv5.quot);
            dig5_reg[1] <= dv5.rem;
            dig5_reg[2] <= d2_reg;
            dig5_reg[3] <= d3_s4_reg;
            dig5_reg[4] <= d4_s4_reg;
        end
    end

    // displayed digits follow every queued redraw
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shown_reg <= '0;
        else if (push.valid)
            shown_reg <= dig5_reg;
    end

endmodule

@@ design/adcv_queue.sv @@
// short queue of pending redraws between front and back
module adcv_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  adcv_pkg::push_t       push,
    input  logic                  pop,
    output adcv_pkg::queue_stat_t qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    adcv_pkg::digits_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.head  = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.digits;
    end

endmodule

@@ design/adcv_back.sv @@
// back end: plays one redraw run as eight lcd write beats
module adcv_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  adcv_pkg::queue_stat_t qstat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_data,
    output logic [7:0]            lcd_byte,
    output logic                  last_write
);

    logic              out_valid_reg;
    logic              is_data_reg;
    logic [7:0]        lcd_byte_reg;
    logic              last_write_reg;
    logic              active_reg;
    logic [2:0]        idx_reg;
    adcv_pkg::digits_t cur_reg;

    logic       slot_free;
    logic [8:0] word_run, word_first;

    assign slot_free  = !out_valid_reg || out_ready;
    assign pop        = slot_free && !active_reg && !qstat.empty;
    assign word_run   = adcv_pkg::beat_word(idx_reg, cur_reg);
    assign word_first = adcv_pkg::beat_word(adcv_pkg::BEAT_CLEAR, qstat.head);

    assign out_valid  = out_valid_reg;
    assign is_data    = is_data_reg;
    assign lcd_byte   = lcd_byte_reg;
    assign last_write = last_write_reg;

    // run sequencing and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            idx_reg       <= adcv_pkg::BEAT_CLEAR;
        end
        else if (slot_free)
        begin
            if (active_reg)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_reg + 3'd1;
                active_reg    <= (idx_reg != adcv_pkg::BEAT_UNIT);
            end
            else if (!qstat.empty)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= adcv_pkg::BEAT_DIG0;
                active_reg    <= 1'b1;
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    // output beat payload and current run digits
    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (active_reg)
            begin
                is_data_reg    <= word_run[8];
                lcd_byte_reg   <= word_run[7:0];
                last_write_reg <= (idx_reg == adcv_pkg::BEAT_UNIT);
            end
            else if (!qstat.empty)
            begin
                cur_reg        <= qstat.head;
                is_data_reg    <= word_first[8];
                lcd_byte_reg   <= word_first[7:0];
                last_write_reg <= 1'b0;
            end
        end
    end

endmodule

@@ design/adc_sample_to_lcd_voltage_text_top.sv @@
// top level of the adc sample to lcd voltage text driver
//
// Input channel: in_valid / in_ready with one 8-bit converter sample per beat.
// Output channel: out_valid / out_ready, each beat one lcd write: is_data
// (register select), lcd_byte and last_write on the final write of a run.
// A sample whose five digits differ from those shown gives a run of eight
// beats: clear command, then "d.dddd" and 'v' as data; otherwise nothing.
// Configuration: cfg_we writes cfg_wdata into the scale register (reset 196),
// clamped to 1..392 on use; write it only while the block is idle.
// Throughput: the front pipeline takes one sample per cycle while in_ready is
// high, and the back end plays one beat of a redraw run per cycle while the
// receiver is ready; runs queued behind one another follow back to back.
// The multiply stage, four divide-by-ten stages, the queue and the output
// register lie between an accepted sample and the first beat of its run.
// A queue of QUEUE_DEPTH runs sits between front and back; when it is full
// and a changed sample reaches the end of the front, in_ready drops.
// When the receiver stalls, the output beat holds and the back end waits.
// Reset clears the pipeline, the queue and the shown digits ("0.0000v").
module adc_sample_to_lcd_voltage_text_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] sample,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_data,
    output logic [7:0] lcd_byte,
    output logic       last_write
);

    logic [8:0]            scale_reg;
    adcv_pkg::push_t       push;
    adcv_pkg::queue_stat_t qstat;
    logic                  pop;

    // scale register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= adcv_pkg::SCALE_RESET;
        else if (cfg_we)
            scale_reg <= cfg_wdata;
    end

    adcv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .scale    (scale_reg),
        .qstat    (qstat),
        .push     (push)
    );

    adcv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .qstat (qstat)
    );

    adcv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_data    (is_data),
        .lcd_byte   (lcd_byte),
        .last_write (last_write)
    );

    // the front only stalls on a full queue
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> qstat.full)
        else $error("front stalled while the queue had room");

    // command beats are always the clear code and never end a run
    a_cmd_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_data |-> lcd_byte == adcv_pkg::LCD_CLEAR && !last_write)
        else $error("command beat other than clear");

    // the final beat of a run is the unit character
    a_last_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_write |-> is_data && lcd_byte == adcv_pkg::CHAR_UNIT)
        else $error("run ended on a beat other than the unit character");

    // a new run starts with the clear command right after a finished run
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_write |=>
            !out_valid || (!is_data && lcd_byte == adcv_pkg::LCD_CLEAR))
        else $error("run did not start with the clear command");

endmodule

@@ test/tb.sv @@
// testbench for the adc sample to lcd voltage text driver, self-checking against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_GAP   = 24;
    localparam int SETTLE_BOUND = 20000;
    localparam int RANDOM_PHASE = 46;

    // one lcd write as seen on the output channel
    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
        logic       last_write;
    } lcd_write_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [8:0] cfg_wdata  = '0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] sample     = '0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last_write;

    // stimulus and prediction state
    logic [7:0] pending_samples [$];
    lcd_write_t redraw_writes [$];
    logic [8:0] scale_shadow  = adcv_pkg::SCALE_RESET;
    adcv_pkg::digits_t shown_shadow = '0;
    int         queued_count  = 0;
    int         taken_count   = 0;
    int         error_count   = 0;
    int         cycle_count   = 0;
    bit         steady        = 1'b0;

    adc_sample_to_lcd_voltage_text_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_data    (is_data),
        .lcd_byte   (lcd_byte),
        .last_write (last_write)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic void push_write(input logic rs, input logic [7:0] b, input logic last);
        lcd_write_t w;
        w.is_data    = rs;
        w.lcd_byte   = b;
        w.last_write = last;
        redraw_writes.push_back(w);
    endfunction

    // digits of sample times clamped scale, eight writes when any digit changed
    function automatic void predict_redraw(input logic [7:0] s);
        logic [8:0]        eff;
        int unsigned       reading;
        adcv_pkg::digits_t fresh;
        bit                differs;
        eff = scale_shadow;
        if (eff < adcv_pkg::SCALE_MIN)
            eff = adcv_pkg::SCALE_MIN;
        if (eff > adcv_pkg::SCALE_MAX)
            eff = adcv_pkg::SCALE_MAX;
        reading = 32'(s) * 32'(eff);
        differs = 1'b0;
        for (int i = adcv_pkg::DIGIT_COUNT - 1; i >= 0; i--)
        begin
            fresh[i] = 4'(reading % 10);
            reading  = reading / 10;
        end
        for (int i = 0; i < adcv_pkg::DIGIT_COUNT; i++)
            if (fresh[i] != shown_shadow[i])
                differs = 1'b1;
        if (differs)
        begin
            push_write(1'b0, adcv_pkg::LCD_CLEAR, 1'b0);
            push_write(1'b1, adcv_pkg::ASCII_ZERO + {4'd0, fresh[0]}, 1'b0);
            push_write(1'b1, adcv_pkg::CHAR_POINT, 1'b0);
            for (int i = 1; i < adcv_pkg::DIGIT_COUNT; i++)
                push_write(1'b1, adcv_pkg::ASCII_ZERO + {4'd0, fresh[i]}, 1'b0);
            push_write(1'b1, adcv_pkg::CHAR_UNIT, 1'b1);
            shown_shadow = fresh;
        end
    endfunction

    // sample driver: holds each beat until accepted, predicts on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_redraw(sample);
                taken_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= 6))
                begin
                    in_valid <= 1'b1;
                    sample   <= pending_samples.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // lcd write monitor with random receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (redraw_writes.size() == 0)
                    report_mismatch($sformatf("unexpected write rs=%0b byte=%02h last=%0b",
                                              is_data, lcd_byte, last_write));
                else
                begin
                    lcd_write_t want;
                    want = redraw_writes.pop_front();
                    if (is_data !== want.is_data)
                        report_mismatch($sformatf("is_data %0b, expected %0b",
                                                  is_data, want.is_data));
                    if (lcd_byte !== want.lcd_byte)
                        report_mismatch($sformatf("lcd_byte %02h, expected %02h",
                                                  lcd_byte, want.lcd_byte));
                    if (last_write !== want.last_write)
                        report_mismatch($sformatf("last_write %0b, expected %0b",
                                                  last_write, want.last_write));
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 6);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(input logic [7:0] s);
        pending_samples.push_back(s);
        queued_count++;
    endtask

    // wait for every sample taken and every write seen, then the pipeline latency
    task automatic settle();
        int spent;
        spent = 0;
        while ((taken_count != queued_count || redraw_writes.size() != 0)
               && spent < SETTLE_BOUND)
        begin
            @(posedge clk);
            spent++;
        end
        repeat (SETTLE_GAP) @(posedge clk);
        if (redraw_writes.size() != 0)
        begin
            report_mismatch($sformatf("%0d writes never arrived", redraw_writes.size()));
            redraw_writes.delete();
        end
    endtask

    task automatic write_scale(input logic [8:0] v);
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= v;
        scale_shadow  = v;
        @(posedge clk);
        cfg_we       <= 1'b0;
    endtask

    // mostly fresh readings, some repeats and one-count steps
    function automatic logic [7:0] next_reading(input logic [7:0] prev);
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return prev;
        else if (roll < 30)
            return $urandom_range(1) ? prev + 8'd1 : prev - 8'd1;
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        logic [7:0] prev;
        logic [8:0] phase_scale;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // default scale: zero right after reset, max, repeat, bit patterns
        send(8'd0);
        send(8'd0);
        send(8'd255);
        send(8'd255);
        send(8'd1);
        send(8'd0);
        send(8'd128);
        send(8'd127);
        send(8'hAA);
        send(8'h55);
        settle();

        // top scale: largest product
        write_scale(adcv_pkg::SCALE_MAX);
        send(8'd255);
        send(8'd0);
        send(8'd1);
        send(8'd254);
        settle();

        // zero scale behaves as one
        write_scale(9'd0);
        send(8'd1);
        send(8'd255);
        send(8'd2);
        settle();

        // scale above the limit saturates
        write_scale(9'h1FF);
        send(8'd255);
        send(8'd100);
        settle();

        write_scale(adcv_pkg::SCALE_MIN);
        send(8'd255);
        send(8'd0);
        settle();

        // random phases over several scales
        prev = 8'd0;
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: phase_scale = 9'($urandom_range(1, 392));
                1: phase_scale = adcv_pkg::SCALE_MAX;
                2: phase_scale = 9'($urandom_range(0, 511));
                3: phase_scale = adcv_pkg::SCALE_MIN;
                default: phase_scale = 9'($urandom_range(1, 40));
            endcase
            write_scale(phase_scale);
            steady = (p == 2);
            for (int k = 0; k < RANDOM_PHASE; k++)
            begin
                prev = next_reading(prev);
                send(prev);
            end
            settle();
            steady = 1'b0;
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
